// ----- sv/arrive_steering_vector_top_defines.svh -----
// Assertion helpers shared by the steering block
`ifndef ARRIVE_STEERING_VECTOR_TOP_DEFINES_SVH
`define ARRIVE_STEERING_VECTOR_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ASV_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ASV_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/asv_pkg.sv -----
package asv_pkg;

  typedef logic signed [31:0] fix_t;
  typedef logic [30:0]        ufix_t;

  localparam fix_t FIX_MAX = 32'sh7fffffff;
  localparam fix_t FIX_MIN = 32'sh80000000;

  // register indexes on the config port
  localparam logic [1:0] REG_TARGET_X    = 2'd0;
  localparam logic [1:0] REG_TARGET_Y    = 2'd1;
  localparam logic [1:0] REG_SLOW_RADIUS = 2'd2;
  localparam logic [1:0] REG_STOP_RADIUS = 2'd3;

  typedef struct packed {
    fix_t  target_x;
    fix_t  target_y;
    ufix_t slow_radius;
    ufix_t stop_radius;
  } cfg_t;

  // agent data after the offset stage
  typedef struct packed {
    fix_t  dx;
    fix_t  dy;
    fix_t  vel_x;
    fix_t  vel_y;
    ufix_t max_speed;
    ufix_t max_accel;
  } agent_t;

  // sideband through the speed divider
  typedef struct packed {
    agent_t      a;
    logic [31:0] dist_len;
    logic        use_max;
    logic        zero;
  } spd_t;

  // sideband through the desired-velocity dividers
  typedef struct packed {
    fix_t  vel_x;
    ufix_t max_accel;
    logic  neg;
  } dsx_t;

  typedef struct packed {
    fix_t vel_y;
    logic neg;
  } dsy_t;

  // word in the queue between front and back
  typedef struct packed {
    fix_t  des_x;
    fix_t  des_y;
    fix_t  vel_x;
    fix_t  vel_y;
    ufix_t max_accel;
  } item_t;

  // steering before the clamp
  typedef struct packed {
    fix_t  sx;
    fix_t  sy;
    ufix_t max_accel;
  } stp_t;

  // sideband through the clamp dividers
  typedef struct packed {
    logic len_zero;
    logic clamp;
    fix_t s;
  } bkx_t;

  typedef struct packed {
    fix_t s;
  } bky_t;

  // a - b saturated to 32 bits
  function automatic fix_t sat_sub(input fix_t a, input fix_t b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    if (d[32] != d[31]) return d[32] ? FIX_MIN : FIX_MAX;
    return d[31:0];
  endfunction

  // magnitude, exact for the most negative value
  function automatic logic [31:0] mag(input fix_t v);
    fix_t n;
    n = -v;
    return v[31] ? 32'(n) : 32'(v);
  endfunction

  // attach a sign to a magnitude below 2^31
  function automatic fix_t apply_sign(input logic neg, input ufix_t m);
    fix_t p;
    p = $signed({1'b0, m});
    return neg ? -p : p;
  endfunction

endpackage

// ----- sv/asv_sqrt_pipe.sv -----
// Pipelined integer square root, one result bit per stage
module asv_sqrt_pipe #(
  parameter int IN_W = 64,
  parameter int SB_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   in_n,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_valid,
  output logic [IN_W/2-1:0] out_root,
  output logic [SB_W-1:0]   out_sb
);

  localparam int STEPS = IN_W / 2;

  logic            vld  [STEPS+1];
  logic [IN_W-1:0] n_q  [STEPS+1];
  logic [IN_W-1:0] r_q  [STEPS+1];
  logic [SB_W-1:0] sb_q [STEPS+1];

  assign vld[0]  = in_valid;
  assign n_q[0]  = in_n;
  assign r_q[0]  = '0;
  assign sb_q[0] = in_sb;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [IN_W-1:0] BIT = {{(IN_W-1){1'b0}}, 1'b1} << (IN_W - 2 - 2*k);
    logic [IN_W-1:0] trial;
    assign trial = r_q[k] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    // try the next root bit
    always_ff @(posedge clk) begin
      if (en) begin
        sb_q[k+1] <= sb_q[k];
        if (n_q[k] >= trial) begin
          n_q[k+1] <= n_q[k] - trial;
          r_q[k+1] <= (r_q[k] >> 1) + BIT;
        end else begin
          n_q[k+1] <= n_q[k];
          r_q[k+1] <= r_q[k] >> 1;
        end
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign out_root  = r_q[STEPS][STEPS-1:0];
  assign out_sb    = sb_q[STEPS];

endmodule

// ----- sv/asv_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// The numerator must stay below den * 2^Q_W.
module asv_div_pipe #(
  parameter int DEN_W = 32,
  parameter int Q_W   = 31,
  parameter int SB_W  = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [DEN_W+Q_W-1:0] in_num,
  input  logic [DEN_W-1:0]     in_den,
  input  logic [SB_W-1:0]      in_sb,
  output logic                 out_valid,
  output logic [Q_W-1:0]       out_q,
  output logic [SB_W-1:0]      out_sb
);

  logic             vld   [Q_W+1];
  logic [DEN_W-1:0] rem_q [Q_W+1];
  logic [Q_W-1:0]   low_q [Q_W+1];
  logic [Q_W-1:0]   quo_q [Q_W+1];
  logic [DEN_W-1:0] den_q [Q_W+1];
  logic [SB_W-1:0]  sb_q  [Q_W+1];

  assign vld[0]   = in_valid;
  assign rem_q[0] = in_num[DEN_W+Q_W-1:Q_W];
  assign low_q[0] = in_num[Q_W-1:0];
  assign quo_q[0] = '0;
  assign den_q[0] = in_den;
  assign sb_q[0]  = in_sb;

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [DEN_W:0] t;
    logic [DEN_W:0] diff;
    logic           ge;
    assign t    = {rem_q[k], low_q[k][Q_W-1]};
    assign diff = t - {1'b0, den_q[k]};
    assign ge   = t >= {1'b0, den_q[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    // shift in one numerator bit, subtract when it fits
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        low_q[k+1] <= low_q[k] << 1;
        quo_q[k+1] <= {quo_q[k][Q_W-2:0], ge};
        den_q[k+1] <= den_q[k];
        sb_q[k+1]  <= sb_q[k];
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign out_q     = quo_q[Q_W];
  assign out_sb    = sb_q[Q_W];

endmodule

// ----- sv/asv_front.sv -----
// Front end: offset, distance, target speed and desired velocity
module asv_front (
  input  logic                clk,
  input  logic                rst,
  input  asv_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  asv_pkg::fix_t       pos_x,
  input  asv_pkg::fix_t       pos_y,
  input  asv_pkg::fix_t       vel_x,
  input  asv_pkg::fix_t       vel_y,
  input  asv_pkg::ufix_t      max_speed,
  input  asv_pkg::ufix_t      max_accel,
  output logic                q_push,
  output asv_pkg::item_t      q_item,
  input  logic                q_full
);

  logic en;

  logic            s1_valid, s2_valid, s3_valid, s5_valid, s6_valid, s7_valid;
  asv_pkg::agent_t s1_a, s2_a, s3_a;
  logic [63:0]     s2_sqx, s2_sqy, s3_sum;

  logic            sq_valid;
  logic [31:0]     sq_dist;
  asv_pkg::agent_t sq_a;

  logic [62:0]     prod;
  logic            use_max, zero;
  logic            s4_valid;
  logic [62:0]     s4_num;
  logic [31:0]     s4_den;
  asv_pkg::spd_t   s4_sb;

  logic            d1_valid;
  logic [30:0]     d1_q;
  asv_pkg::spd_t   d1_sb;

  asv_pkg::ufix_t  s5_speed;
  asv_pkg::spd_t   s5_sb;

  logic [62:0]     s6_num_x, s6_num_y;
  logic [31:0]     s6_den;
  asv_pkg::dsx_t   s6_sbx;
  asv_pkg::dsy_t   s6_sby;

  logic            dx_valid, dy_valid;
  logic [30:0]     dx_q, dy_q;
  asv_pkg::dsx_t   dx_sb;
  asv_pkg::dsy_t   dy_sb;

  asv_pkg::item_t  s7_item;

  // whole front advances unless the last word is blocked by a full queue
  assign en       = !(s7_valid && q_full);
  assign in_ready = en;
  assign q_push   = s7_valid && en;
  assign q_item   = s7_item;

  // valid chain for the stages built here
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= sq_valid;
      s5_valid <= d1_valid;
      s6_valid <= s5_valid;
      s7_valid <= dx_valid && dy_valid;
    end
  end

  // offset to target, then squares, then sum
  always_ff @(posedge clk) begin
    if (en) begin
      s1_a   <= '{dx:        asv_pkg::sat_sub(cfg.target_x, pos_x),
                  dy:        asv_pkg::sat_sub(cfg.target_y, pos_y),
                  vel_x:     vel_x,
                  vel_y:     vel_y,
                  max_speed: max_speed,
                  max_accel: max_accel};
      s2_sqx <= asv_pkg::mag(s1_a.dx) * asv_pkg::mag(s1_a.dx);
      s2_sqy <= asv_pkg::mag(s1_a.dy) * asv_pkg::mag(s1_a.dy);
      s2_a   <= s1_a;
      s3_sum <= s2_sqx + s2_sqy;
      s3_a   <= s2_a;
    end
  end

  asv_sqrt_pipe #(.IN_W(64), .SB_W($bits(asv_pkg::agent_t))) u_dist (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s3_valid),
    .in_n     (s3_sum),
    .in_sb    (s3_a),
    .out_valid(sq_valid),
    .out_root (sq_dist),
    .out_sb   (sq_a)
  );

  // speed selection and slow-down numerator
  assign prod    = 63'(sq_a.max_speed) * 63'(sq_dist);
  assign use_max = sq_dist > {1'b0, cfg.slow_radius};
  assign zero    = (sq_dist <= {1'b0, cfg.stop_radius}) || (sq_dist == '0) ||
                   (!use_max && (cfg.slow_radius == '0));

  always_ff @(posedge clk) begin
    if (en) begin
      s4_num <= (use_max || (cfg.slow_radius == '0)) ? '0 : prod;
      s4_den <= (cfg.slow_radius == '0) ? 32'd1 : {1'b0, cfg.slow_radius};
      s4_sb  <= '{a: sq_a, dist_len: sq_dist, use_max: use_max, zero: zero};
    end
  end

  asv_div_pipe #(.DEN_W(32), .Q_W(31), .SB_W($bits(asv_pkg::spd_t))) u_speed (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s4_valid),
    .in_num   (s4_num),
    .in_den   (s4_den),
    .in_sb    (s4_sb),
    .out_valid(d1_valid),
    .out_q    (d1_q),
    .out_sb   (d1_sb)
  );

  // target speed, then |d| * speed over the distance
  always_ff @(posedge clk) begin
    if (en) begin
      s5_speed <= d1_sb.zero ? '0 : (d1_sb.use_max ? d1_sb.a.max_speed : d1_q);
      s5_sb    <= d1_sb;
      s6_num_x <= 63'(asv_pkg::mag(s5_sb.a.dx)) * 63'(s5_speed);
      s6_num_y <= 63'(asv_pkg::mag(s5_sb.a.dy)) * 63'(s5_speed);
      s6_den   <= (s5_sb.dist_len == '0) ? 32'd1 : s5_sb.dist_len;
      s6_sbx   <= '{vel_x: s5_sb.a.vel_x, max_accel: s5_sb.a.max_accel,
                    neg: s5_sb.a.dx[31]};
      s6_sby   <= '{vel_y: s5_sb.a.vel_y, neg: s5_sb.a.dy[31]};
    end
  end

  asv_div_pipe #(.DEN_W(32), .Q_W(31), .SB_W($bits(asv_pkg::dsx_t))) u_des_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s6_valid),
    .in_num   (s6_num_x),
    .in_den   (s6_den),
    .in_sb    (s6_sbx),
    .out_valid(dx_valid),
    .out_q    (dx_q),
    .out_sb   (dx_sb)
  );

  asv_div_pipe #(.DEN_W(32), .Q_W(31), .SB_W($bits(asv_pkg::dsy_t))) u_des_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s6_valid),
    .in_num   (s6_num_y),
    .in_den   (s6_den),
    .in_sb    (s6_sby),
    .out_valid(dy_valid),
    .out_q    (dy_q),
    .out_sb   (dy_sb)
  );

  // desired velocity word for the queue
  always_ff @(posedge clk) begin
    if (en) begin
      s7_item <= '{des_x:     asv_pkg::apply_sign(dx_sb.neg, dx_q),
                   des_y:     asv_pkg::apply_sign(dy_sb.neg, dy_q),
                   vel_x:     dx_sb.vel_x,
                   vel_y:     dy_sb.vel_y,
                   max_accel: dx_sb.max_accel};
    end
  end

endmodule

// ----- sv/asv_fifo.sv -----
`include "arrive_steering_vector_top_defines.svh"

// Small register queue between front and back
module asv_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  asv_pkg::item_t item_in,
  output logic           full,
  input  logic           pop,
  output asv_pkg::item_t item_out,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  asv_pkg::item_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == FULL_CNT;
  assign empty    = count == '0;
  assign item_out = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= item_in;
  end

  `ASV_ASSERT_IMP(a_no_overflow, push, !full, "queue written while full")
  `ASV_ASSERT_IMP(a_no_underflow, pop, !empty, "queue read while empty")
  `ASV_ASSERT_NXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "count did not grow")

endmodule

// ----- sv/asv_back.sv -----
// Back end: steering = desired - velocity, clamped to max acceleration
module asv_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  asv_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output asv_pkg::fix_t  steer_x,
  output asv_pkg::fix_t  steer_y
);

  logic en;

  logic           b1_valid, b2_valid, b3_valid, b4_valid, b5_valid;
  asv_pkg::stp_t  b1_s, b2_s, b3_s;
  logic [63:0]    b2_sqx, b2_sqy, b3_sum;

  logic           sq_valid;
  logic [31:0]    sq_len;
  asv_pkg::stp_t  sq_s;

  logic [62:0]    prod_x, prod_y;
  logic           clamp;
  logic [62:0]    b4_num_x, b4_num_y;
  logic [31:0]    b4_den;
  asv_pkg::bkx_t  b4_sbx;
  asv_pkg::bky_t  b4_sby;

  logic           cx_valid, cy_valid;
  logic [30:0]    cx_q, cy_q;
  asv_pkg::bkx_t  cx_sb;
  asv_pkg::bky_t  cy_sb;

  // advance unless the output register holds a word not yet taken
  assign en        = !b5_valid || out_ready;
  assign q_pop     = en && !q_empty;
  assign out_valid = b5_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      b3_valid <= 1'b0;
      b4_valid <= 1'b0;
      b5_valid <= 1'b0;
    end else if (en) begin
      b1_valid <= !q_empty;
      b2_valid <= b1_valid;
      b3_valid <= b2_valid;
      b4_valid <= sq_valid;
      b5_valid <= cx_valid && cy_valid;
    end
  end

  // raw steering, squares, sum
  always_ff @(posedge clk) begin
    if (en) begin
      b1_s   <= '{sx:        asv_pkg::sat_sub(q_item.des_x, q_item.vel_x),
                  sy:        asv_pkg::sat_sub(q_item.des_y, q_item.vel_y),
                  max_accel: q_item.max_accel};
      b2_sqx <= asv_pkg::mag(b1_s.sx) * asv_pkg::mag(b1_s.sx);
      b2_sqy <= asv_pkg::mag(b1_s.sy) * asv_pkg::mag(b1_s.sy);
      b2_s   <= b1_s;
      b3_sum <= b2_sqx + b2_sqy;
      b3_s   <= b2_s;
    end
  end

  asv_sqrt_pipe #(.IN_W(64), .SB_W($bits(asv_pkg::stp_t))) u_len (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (b3_valid),
    .in_n     (b3_sum),
    .in_sb    (b3_s),
    .out_valid(sq_valid),
    .out_root (sq_len),
    .out_sb   (sq_s)
  );

  // clamp numerators, scaled by max_accel over the length
  assign prod_x = 63'(asv_pkg::mag(sq_s.sx)) * 63'(sq_s.max_accel);
  assign prod_y = 63'(asv_pkg::mag(sq_s.sy)) * 63'(sq_s.max_accel);
  assign clamp  = sq_len > {1'b0, sq_s.max_accel};

  always_ff @(posedge clk) begin
    if (en) begin
      b4_num_x <= clamp ? prod_x : '0;
      b4_num_y <= clamp ? prod_y : '0;
      b4_den   <= clamp ? sq_len : 32'd1;
      b4_sbx   <= '{len_zero: sq_len == '0, clamp: clamp, s: sq_s.sx};
      b4_sby   <= '{s: sq_s.sy};
    end
  end

  asv_div_pipe #(.DEN_W(32), .Q_W(31), .SB_W($bits(asv_pkg::bkx_t))) u_clamp_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (b4_valid),
    .in_num   (b4_num_x),
    .in_den   (b4_den),
    .in_sb    (b4_sbx),
    .out_valid(cx_valid),
    .out_q    (cx_q),
    .out_sb   (cx_sb)
  );

  asv_div_pipe #(.DEN_W(32), .Q_W(31), .SB_W($bits(asv_pkg::bky_t))) u_clamp_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (b4_valid),
    .in_num   (b4_num_y),
    .in_den   (b4_den),
    .in_sb    (b4_sby),
    .out_valid(cy_valid),
    .out_q    (cy_q),
    .out_sb   (cy_sb)
  );

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (cx_sb.len_zero) begin
        steer_x <= '0;
        steer_y <= '0;
      end else if (cx_sb.clamp) begin
        steer_x <= asv_pkg::apply_sign(cx_sb.s[31], cx_q);
        steer_y <= asv_pkg::apply_sign(cy_sb.s[31], cy_q);
      end else begin
        steer_x <= cx_sb.s;
        steer_y <= cy_sb.s;
      end
    end
  end

endmodule

// ----- sv/arrive_steering_vector_top.sv -----
// Arrive steering: for each agent word (position, velocity, max speed, max
// acceleration) returns the Q16.16 steering acceleration toward the target set
// in the config registers, slowing inside the slow radius and stopping inside
// the stop radius. One word is accepted per clock while the queue is not full,
// and one result leaves per clock while the output is taken. The front end
// (distance square root, speed divider, desired-velocity dividers, one bit per
// stage) feeds a queue ahead of the back end (length square root and clamp
// dividers), which lets the front keep accepting while the output stalls.
// Write config only while no word is in flight.
module arrive_steering_vector_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  // pos_x, pos_y, vel_x, vel_y, max_speed, max_accel, zero pad
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,
  // steer_x, steer_y
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  asv_pkg::cfg_t  cfg;
  logic           q_push, q_full, q_pop, q_empty;
  asv_pkg::item_t q_in, q_out;
  asv_pkg::fix_t  steer_x, steer_y;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        asv_pkg::REG_TARGET_X:    cfg.target_x    <= cfg_data;
        asv_pkg::REG_TARGET_Y:    cfg.target_y    <= cfg_data;
        asv_pkg::REG_SLOW_RADIUS: cfg.slow_radius <= cfg_data[30:0];
        asv_pkg::REG_STOP_RADIUS: cfg.stop_radius <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  asv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .pos_x    (s_tdata[31:0]),
    .pos_y    (s_tdata[63:32]),
    .vel_x    (s_tdata[95:64]),
    .vel_y    (s_tdata[127:96]),
    .max_speed(s_tdata[158:128]),
    .max_accel(s_tdata[189:159]),
    .q_push   (q_push),
    .q_item   (q_in),
    .q_full   (q_full)
  );

  asv_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .item_in (q_in),
    .full    (q_full),
    .pop     (q_pop),
    .item_out(q_out),
    .empty   (q_empty)
  );

  asv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_item   (q_out),
    .q_pop    (q_pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .steer_x  (steer_x),
    .steer_y  (steer_y)
  );

  assign m_tdata = {steer_y, steer_x};

endmodule
